### rtl/pitch_gap_log_interpolator_unit_defines.svh
// Assertion macros for the pitch gap interpolator
`ifndef PITCH_GAP_LOG_INTERPOLATOR_UNIT_DEFINES_SVH
`define PITCH_GAP_LOG_INTERPOLATOR_UNIT_DEFINES_SVH
`ifndef SYNTH
`define PGLI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PGLI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PGLI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PGLI_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/pgli_pkg.sv
package pgli_pkg;
    localparam int MAX_GAP = 63;
    localparam int GAP_W = 6;
    localparam int HZ_W = 16;
    localparam int LOG_W = 20;  // Q4.16 for raw 16-bit values

    typedef struct packed {
        logic           start;   // start one interpolation
        logic           load;    // start log of both ends
        logic [GAP_W-1:0] k;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } dp_stat_t;
endpackage

### rtl/pgli_log2.sv
// Sequential log2 in Q4.16: one squaring per cycle.
module pgli_log2 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] x,
    output logic        done,
    output logic [19:0] result
);
    import pgli_pkg::*;
    logic [16:0] m_reg, m_next;
    logic [15:0] frac_reg, frac_next;
    logic [3:0]  e_reg, e_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  e_c;
    logic [33:0] sq;
    logic [17:0] ms;

    // priority encoder for the top bit
    always_comb
    begin
        e_c = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (x[i])
                e_c = 4'(i);
        end
    end

    assign sq = {17'd0, m_reg} * {17'd0, m_reg};
    assign ms = sq[33:16];

    always_comb
    begin
        m_next = m_reg;
        frac_next = frac_reg;
        e_next = e_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            m_next = 17'(({1'b0, x, 16'd0}) >> e_c);
            e_next = e_c;
            frac_next = 16'd0;
            cnt_next = 5'd16;
            busy_next = (x != 16'd0);
            done_next = (x == 16'd0);
        end
        else if (busy_reg)
        begin
            if (ms >= 18'h20000)
            begin
                m_next = ms[17:1];
                frac_next = frac_reg | (16'd1 << (cnt_reg - 5'd1));
            end
            else
                m_next = ms[16:0];
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg <= m_next;
        frac_reg <= frac_next;
        e_reg <= e_next;
    end

    assign done = done_reg;
    assign result = (m_reg == 17'd0 && e_reg == 4'd0 && frac_reg == 16'd0) ?
                    20'd0 : {e_reg, frac_reg};
endmodule

### rtl/pgli_datapath.sv
// Interpolation datapath: endpoint logs, weighted sum, restoring divide,
// bisection search of the inverse log, clamp.
module pgli_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pgli_pkg::dp_cmd_t    cmd,
    input  logic [15:0]          a,
    input  logic [15:0]          b,
    input  logic [5:0]           g,
    output pgli_pkg::dp_stat_t   stat,
    output logic [15:0]          y
);
    import pgli_pkg::*;

    typedef enum logic [5:0] {
        D_IDLE = 6'b000001,
        D_LA   = 6'b000010,
        D_LB   = 6'b000100,
        D_DIV  = 6'b001000,
        D_SRCH = 6'b010000,
        D_WAIT = 6'b100000
    } dstate_t;

    dstate_t     st_reg, st_next;
    logic        lg_start;
    logic [15:0] lg_x;
    logic        lg_done;
    logic [19:0] lg_res;
    logic [19:0] la_reg, la_next, lb_reg, lb_next;
    logic [26:0] num_reg, num_next;     // weighted sum
    logic [26:0] rem_reg, rem_next;
    logic [20:0] q_reg, q_next;         // quotient v
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [15:0] y_reg, y_next;
    logic        done_reg, done_next;
    logic [6:0]  d;
    logic [26:0] wsum;
    logic [27:0] trial;
    logic [15:0] mn, mx, midc;

    pgli_log2 u_log (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lg_start),
        .x      (lg_x),
        .done   (lg_done),
        .result (lg_res)
    );

    assign d = {1'b0, g} + 7'd1;
    assign mn = (a < b) ? a : b;
    assign mx = (a < b) ? b : a;
    assign midc = 16'((({1'b0, lo_reg} + {1'b0, hi_reg} + 17'd1)) >> 1);
    assign wsum = 27'(la_reg * (d - {1'b0, cmd.k})) + 27'(lb_reg * {1'b0, cmd.k})
                  + 27'(d >> 1);
    assign trial = {rem_reg, num_reg[26]} - {21'd0, d};

    always_comb
    begin
        st_next = st_reg;
        la_next = la_reg;
        lb_next = lb_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        mid_next = mid_reg;
        y_next = y_reg;
        done_next = 1'b0;
        lg_start = 1'b0;
        lg_x = a;
        case (st_reg)
            D_IDLE:
            begin
                if (cmd.load)
                begin
                    lg_start = 1'b1;
                    lg_x = a;
                    st_next = D_LA;
                end
                else if (cmd.start)
                begin
                    num_next = wsum;
                    rem_next = 27'd0;
                    cnt_next = 5'd27 - 5'd1;
                    q_next = 21'd0;
                    st_next = D_DIV;
                end
            end
            D_LA:
            begin
                if (lg_done)
                begin
                    la_next = lg_res;
                    lg_start = 1'b1;
                    lg_x = b;
                    st_next = D_LB;
                end
            end
            D_LB:
            begin
                if (lg_done)
                begin
                    lb_next = lg_res;
                    done_next = 1'b1;
                    st_next = D_IDLE;
                end
            end
            D_DIV:
            begin
                // one quotient bit a cycle
                if (!trial[27])
                begin
                    rem_next = trial[26:0];
                    q_next = {q_reg[19:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[25:0], num_reg[26]};
                    q_next = {q_reg[19:0], 1'b0};
                end
                num_next = {num_reg[25:0], 1'b0};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    lo_next = 16'd1;
                    hi_next = 16'hFFFF;
                    st_next = D_SRCH;
                end
            end
            D_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next = midc;
                    lg_start = 1'b1;
                    lg_x = midc;
                    st_next = D_WAIT;
                end
                else
                begin
                    y_next = (lo_reg < mn) ? mn : ((lo_reg > mx) ? mx : lo_reg);
                    done_next = 1'b1;
                    st_next = D_IDLE;
                end
            end
            D_WAIT:
            begin
                lg_x = mid_reg;
                if (lg_done)
                begin
                    if ({1'b0, lg_res} <= q_reg)
                        lo_next = mid_reg;
                    else
                        hi_next = mid_reg - 16'd1;
                    st_next = D_SRCH;
                end
            end
            default: st_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= D_IDLE;
            done_reg <= 1'b0;
            cnt_reg <= 5'd0;
        end
        else
        begin
            st_reg <= st_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        la_reg <= la_next;
        lb_reg <= lb_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg <= q_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        mid_reg <= mid_next;
        y_reg <= y_next;
    end

    assign stat.busy = (st_reg != D_IDLE);
    assign stat.done = done_reg;
    assign y = y_reg;
endmodule

### rtl/pgli_ctrl.sv
// Frame controller: voicing, gap count, release sequencing, output register.
`include "pitch_gap_log_interpolator_unit_defines.svh"
module pgli_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               use_mask_wr,
    input  logic               use_mask_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        pitch_hz,
    input  logic               voiced_bit,
    input  logic               curve_end,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        filled_hz,
    output logic               run_last,
    output logic               gap_overflow,
    output pgli_pkg::dp_cmd_t  cmd,
    input  pgli_pkg::dp_stat_t stat,
    input  logic [15:0]        dp_y,
    output logic [15:0]        dp_a,
    output logic [15:0]        dp_b,
    output logic [5:0]         dp_g
);
    import pgli_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_OVF   = 7'b0000010,  // emit overflow frame
        S_TRAIL = 7'b0000100,  // emit held frames at curve end
        S_LOAD  = 7'b0001000,  // endpoint logs
        S_INTP  = 7'b0010000,  // one gap frame
        S_GAPO  = 7'b0100000,  // emit gap frame
        S_VOIC  = 7'b1000000   // emit voiced frame
    } state_t;

    state_t      st_reg, st_next;
    logic        use_mask_reg;
    logic [15:0] held_reg, held_next;
    logic        have_reg, have_next;
    logic [5:0]  gap_reg, gap_next;
    logic [5:0]  k_reg, k_next;
    logic [15:0] p_reg, p_next;
    logic        end_reg, end_next;
    logic        ov_valid_reg, ov_valid_next;
    logic [15:0] o_hz_reg, o_hz_next;
    logic        o_last_reg, o_last_next, o_ovf_reg, o_ovf_next;
    logic        o_free, accept, voiced;
    logic [15:0] hv;
    logic        started_reg, started_next;

    assign o_free = !ov_valid_reg || out_ready;
    assign in_ready = (st_reg == S_IDLE);
    assign accept = in_valid && in_ready;
    assign voiced = (pitch_hz != 16'd0) && (!use_mask_reg || voiced_bit);
    assign hv = have_reg ? held_reg : 16'd0;

    always_comb
    begin
        st_next = st_reg;
        held_next = held_reg;
        have_next = have_reg;
        gap_next = gap_reg;
        k_next = k_reg;
        p_next = p_reg;
        end_next = end_reg;
        started_next = 1'b0;
        ov_valid_next = ov_valid_reg && !out_ready;
        o_hz_next = o_hz_reg;
        o_last_next = o_last_reg;
        o_ovf_next = o_ovf_reg;
        cmd.start = 1'b0;
        cmd.load = 1'b0;
        cmd.k = k_reg;
        case (st_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    p_next = pitch_hz;
                    end_next = curve_end;
                    k_next = 6'd1;
                    if (voiced)
                    begin
                        if (gap_reg != 6'd0 && have_reg)
                            st_next = S_LOAD;
                        else
                            st_next = (gap_reg != 6'd0) ? S_GAPO : S_VOIC;
                    end
                    else
                    begin
                        if (gap_reg < 6'(MAX_GAP))
                            gap_next = gap_reg + 6'd1;
                        if (gap_reg >= 6'(MAX_GAP))
                            st_next = S_OVF;
                        else if (curve_end)
                            st_next = S_TRAIL;
                        else
                            st_next = S_IDLE;
                        k_next = 6'd0;
                    end
                end
            end
            S_OVF:
            begin
                if (o_free)
                begin
                    ov_valid_next = 1'b1;
                    o_hz_next = hv;
                    o_ovf_next = 1'b1;
                    o_last_next = !end_reg;
                    st_next = end_reg ? S_TRAIL : S_IDLE;
                end
            end
            S_TRAIL:
            begin
                if (o_free)
                begin
                    ov_valid_next = 1'b1;
                    o_hz_next = hv;
                    o_ovf_next = 1'b0;
                    o_last_next = (k_reg + 6'd1 == gap_reg);
                    k_next = k_reg + 6'd1;
                    if (k_reg + 6'd1 == gap_reg)
                    begin
                        st_next = S_IDLE;
                        gap_next = 6'd0;
                        have_next = 1'b0;
                        held_next = 16'd0;
                    end
                end
            end
            S_LOAD:
            begin
                if (!started_reg && !stat.busy)
                begin
                    cmd.load = 1'b1;
                    started_next = 1'b1;
                end
                if (stat.done)
                    st_next = S_INTP;
            end
            S_INTP:
            begin
                if (!started_reg && !stat.busy && !stat.done)
                begin
                    cmd.start = 1'b1;
                    started_next = 1'b1;
                end
                if (stat.done)
                    st_next = S_GAPO;
            end
            S_GAPO:
            begin
                if (o_free)
                begin
                    ov_valid_next = 1'b1;
                    o_hz_next = have_reg ? dp_y : p_reg;
                    o_ovf_next = 1'b0;
                    o_last_next = 1'b0;
                    k_next = k_reg + 6'd1;
                    if (k_reg == gap_reg)
                        st_next = S_VOIC;
                    else
                        st_next = have_reg ? S_INTP : S_GAPO;
                end
            end
            S_VOIC:
            begin
                if (o_free)
                begin
                    ov_valid_next = 1'b1;
                    o_hz_next = p_reg;
                    o_ovf_next = 1'b0;
                    o_last_next = 1'b1;
                    gap_next = 6'd0;
                    held_next = end_reg ? 16'd0 : p_reg;
                    have_next = !end_reg;
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
        // unvoiced curve end with nothing waiting never happens: gap >= 1
        if (st_reg == S_IDLE && accept && !voiced && curve_end &&
            gap_reg >= 6'(MAX_GAP))
            k_next = 6'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            use_mask_reg <= 1'b1;
            held_reg <= 16'd0;
            have_reg <= 1'b0;
            gap_reg <= 6'd0;
            ov_valid_reg <= 1'b0;
            started_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (use_mask_wr)
                use_mask_reg <= use_mask_data;
            held_reg <= held_next;
            have_reg <= have_next;
            gap_reg <= gap_next;
            ov_valid_reg <= ov_valid_next;
            started_reg <= started_next || (started_reg && !stat.done);
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        p_reg <= p_next;
        end_reg <= end_next;
        o_hz_reg <= o_hz_next;
        o_last_reg <= o_last_next;
        o_ovf_reg <= o_ovf_next;
    end

    assign out_valid = ov_valid_reg;
    assign filled_hz = o_hz_reg;
    assign run_last = o_last_reg;
    assign gap_overflow = o_ovf_reg;
    assign dp_a = held_reg;
    assign dp_b = p_reg;
    assign dp_g = gap_reg;

    `PGLI_ASSERT_IMP(a_gap_max, clk, rst_n, 1'b1, gap_reg <= 6'(MAX_GAP))
    `PGLI_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(filled_hz))
    `PGLI_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, !stat.busy)
endmodule

### rtl/pitch_gap_log_interpolator_unit.sv
// Pitch gap filler: voiced frames pass through; unvoiced gaps are released
// when they close, interpolated geometrically in the log2 domain between
// neighboring voiced frames. One result register feeds the output; the input
// is taken only between items. A voiced frame closing a gap of G frames with
// a held value first runs the two endpoint logs, then per gap frame a 27-step
// restoring divide and a bisection of up to 16 probes, each probe a serial
// log2 (one squaring a cycle) plus the compare. A gap with no held value
// takes the next voiced value; a trailing gap at curve end holds the held
// value or zero. Output stalls can hold every frame.
module pitch_gap_log_interpolator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        use_mask_we,
    input  logic        use_mask_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] pitch_hz,
    input  logic        voiced_bit,
    input  logic        curve_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] filled_hz,
    output logic        run_last,
    output logic        gap_overflow
);
    import pgli_pkg::*;
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [15:0] dp_y, dp_a, dp_b;
    logic [5:0]  dp_g;

    pgli_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .use_mask_wr(use_mask_we), .use_mask_data(use_mask_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .pitch_hz(pitch_hz), .voiced_bit(voiced_bit), .curve_end(curve_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .filled_hz(filled_hz), .run_last(run_last), .gap_overflow(gap_overflow),
        .cmd(cmd), .stat(stat), .dp_y(dp_y),
        .dp_a(dp_a), .dp_b(dp_b), .dp_g(dp_g)
    );

    pgli_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .a(dp_a), .b(dp_b), .g(dp_g), .stat(stat), .y(dp_y)
    );
endmodule

### tb/tb_pitch_gap_log_interpolator_unit.sv
`timescale 1ns / 1ps

module tb_pitch_gap_log_interpolator_unit;
    import pgli_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 80;
    localparam int RAND_ITEMS = 220;

    typedef struct {
        logic [HZ_W-1:0] hz;
        logic            last;
        logic            ovf;
    } fill_res_t;

    typedef struct {
        logic [HZ_W-1:0] hz;
        logic            vb;
        logic            cend;
        logic            lit_en;
        logic [HZ_W-1:0] lit_hz;
    } frame_row_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            use_mask_we = 1'b0;
    logic            use_mask_wdata = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_ready;
    logic [15:0]     pitch_hz = '0;
    logic            voiced_bit = 1'b0;
    logic            curve_end = 1'b0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    logic [15:0]     filled_hz;
    logic            run_last;
    logic            gap_overflow;

    // predictor state
    logic            mdl_use_mask;
    logic [HZ_W-1:0] mdl_held;
    logic            mdl_have_held;
    int              mdl_gap;

    fill_res_t       fill_q[$];
    int              fail_cnt = 0;
    int              stall_cnt = 0;
    int              item_cnt = 0;
    logic            no_idle = 1'b0;

    pitch_gap_log_interpolator_unit dut (
        .clk(clk), .rst_n(rst_n),
        .use_mask_we(use_mask_we), .use_mask_wdata(use_mask_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .pitch_hz(pitch_hz), .voiced_bit(voiced_bit), .curve_end(curve_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .filled_hz(filled_hz), .run_last(run_last), .gap_overflow(gap_overflow)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // log2 of the raw value in Q4.16, by repeated squaring of the mantissa
    function automatic logic [31:0] log2_q16(input logic [15:0] x);
        logic [63:0] m;
        logic [15:0] frac;
        int          top;
        top = 0;
        frac = '0;
        if (x == 16'd0)
            return 32'd0;
        for (int i = 0; i < 16; i++)
            if (x[i])
                top = i;
        m = ({48'd0, x} << 16) >> top;
        for (int i = 16; i > 0; i--)
        begin
            m = (m * m) >> 16;
            if (m >= 64'h20000)
            begin
                m = m >> 1;
                frac[i-1] = 1'b1;
            end
        end
        return (top << 16) | frac;
    endfunction

    // geometric fill of gap frame k out of g between voiced a and b
    function automatic logic [15:0] geo_fill(input logic [15:0] a, input logic [15:0] b,
                                             input int k, input int g);
        logic [63:0] la, lb, d, v;
        int          lo, hi, mid;
        int          mn, mx;
        la = log2_q16(a);
        lb = log2_q16(b);
        d = g + 1;
        v = (la * (d - k) + lb * k + d / 2) / d;
        lo = 1;
        hi = 65535;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (log2_q16(mid[15:0]) <= v)
                lo = mid;
            else
                hi = mid - 1;
        end
        mn = (a < b) ? a : b;
        mx = (a < b) ? b : a;
        if (lo < mn)
            lo = mn;
        if (lo > mx)
            lo = mx;
        return lo[15:0];
    endfunction

    function automatic void push_fill(input logic [15:0] hz, input logic ovf);
        fill_res_t r;
        r.hz = hz;
        r.last = 1'b0;
        r.ovf = ovf;
        fill_q.insert(fill_q.size(), r);
    endfunction

    // expected frames for one accepted item
    function automatic void predict_frame(input logic [15:0] p, input logic vb,
                                          input logic cend);
        int    n0;
        logic  voiced;
        n0 = fill_q.size();
        voiced = (p != 16'd0) && (!mdl_use_mask || vb);
        if (voiced)
        begin
            for (int k = 1; k <= mdl_gap; k++)
                push_fill(mdl_have_held ? geo_fill(mdl_held, p, k, mdl_gap) : p, 1'b0);
            push_fill(p, 1'b0);
            mdl_held = p;
            mdl_have_held = 1'b1;
            mdl_gap = 0;
        end
        else
        begin
            if (mdl_gap >= MAX_GAP)
            begin
                push_fill(mdl_have_held ? mdl_held : 16'd0, 1'b1);
                mdl_gap = MAX_GAP;
            end
            else
                mdl_gap++;
            if (cend)
                for (int k = 0; k < mdl_gap; k++)
                    push_fill(mdl_have_held ? mdl_held : 16'd0, 1'b0);
        end
        if (cend)
        begin
            mdl_held = '0;
            mdl_have_held = 1'b0;
            mdl_gap = 0;
        end
        if (fill_q.size() > n0)
            fill_q[$].last = 1'b1;
    endfunction

    // send one item, idling at random before it
    task automatic send_frame(input logic [15:0] p, input logic vb, input logic cend);
        while (!no_idle && $urandom_range(0, 99) < 22)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pitch_hz <= p;
        voiced_bit <= vb;
        curve_end <= cend;
        do
            @(posedge clk);
        while (!in_ready);
        predict_frame(p, vb, cend);
        item_cnt++;
    endtask

    task automatic drain_all;
        in_valid <= 1'b0;
        @(posedge clk);
        while (fill_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mask(input logic val);
        drain_all();
        use_mask_we <= 1'b1;
        use_mask_wdata <= val;
        @(posedge clk);
        use_mask_we <= 1'b0;
        mdl_use_mask = val;
    endtask

    // receiver stalls
    always @(posedge clk)
        out_ready <= no_idle || ($urandom_range(0, 99) >= 22);

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (fill_q.size() == 0)
            begin
                $display("%0t: unexpected frame, expected none, actual hz=%h last=%b ovf=%b",
                         $time, filled_hz, run_last, gap_overflow);
                fail_cnt++;
            end
            else
            begin
                fill_res_t e;
                e = fill_q.pop_front();
                if (filled_hz !== e.hz)
                begin
                    $display("%0t: filled_hz expected %h actual %h", $time, e.hz, filled_hz);
                    fail_cnt++;
                end
                if (run_last !== e.last)
                begin
                    $display("%0t: run_last expected %b actual %b", $time, e.last, run_last);
                    fail_cnt++;
                end
                if (gap_overflow !== e.ovf)
                begin
                    $display("%0t: gap_overflow expected %b actual %b", $time, e.ovf,
                             gap_overflow);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog on accepted items in either direction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt > STALL_LIMIT)
        begin
            $display("tb_pitch_gap_log_interpolator_unit NOT OK");
            $finish;
        end
    end

    // directed frames; lit_hz is the last frame the item must produce
    frame_row_t dir_tab[19] = '{
        '{16'hFFFF, 1'b1, 1'b0, 1'b1, 16'hFFFF},  // top pitch passes
        '{16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000},  // no pitch
        '{16'h0064, 1'b0, 1'b0, 1'b0, 16'h0000},  // masked out
        '{16'h0001, 1'b1, 1'b0, 1'b1, 16'h0001},  // closes gap, wide span
        '{16'h0000, 1'b0, 1'b1, 1'b1, 16'h0001},  // trailing gap holds
        '{16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{16'h0005, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{16'h1234, 1'b1, 1'b0, 1'b1, 16'h1234},  // leading gap takes next
        '{16'h00A0, 1'b1, 1'b0, 1'b1, 16'h00A0},
        '{16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000},
        '{16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{16'h0280, 1'b1, 1'b0, 1'b1, 16'h0280},  // gap of three, narrow
        '{16'h0000, 1'b1, 1'b1, 1'b1, 16'h0280},  // curve end holds last voiced
        '{16'h0000, 1'b0, 1'b1, 1'b1, 16'h0000},  // end with nothing held
        '{16'h7FFF, 1'b1, 1'b1, 1'b1, 16'h7FFF},  // voiced end frame
        '{16'h0010, 1'b1, 1'b0, 1'b1, 16'h0010},
        '{16'hFFFF, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{16'h0011, 1'b1, 1'b1, 1'b1, 16'h0011}   // adjacent values
    };

    initial
    begin
        logic [15:0] p;
        logic [15:0] lit_act;
        int          g, nseg;
        mdl_use_mask = 1'b1;
        mdl_held = '0;
        mdl_have_held = 1'b0;
        mdl_gap = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            send_frame(dir_tab[i].hz, dir_tab[i].vb, dir_tab[i].cend);
            if (dir_tab[i].lit_en)
            begin
                lit_act = (fill_q.size() == 0) ? 16'hxxxx : fill_q[$].hz;
                if (lit_act !== dir_tab[i].lit_hz)
                begin
                    $display("%0t: row %0d expected %h actual %h", $time, i,
                             dir_tab[i].lit_hz, lit_act);
                    fail_cnt++;
                end
            end
        end

        // overflow with a held value, then a full-length fill
        send_frame(16'd800, 1'b1, 1'b0);
        for (int i = 0; i < MAX_GAP + 3; i++)
            send_frame(16'd0, 1'b0, 1'b0);
        send_frame(16'd900, 1'b1, 1'b1);
        // overflow with nothing held
        for (int i = 0; i < MAX_GAP + 2; i++)
            send_frame(16'd0, 1'b1, i == MAX_GAP + 1);

        // mask off: pitch alone decides
        write_mask(1'b0);
        send_frame(16'd100, 1'b0, 1'b0);
        send_frame(16'd0, 1'b1, 1'b0);
        send_frame(16'd400, 1'b0, 1'b1);

        // random curves
        item_cnt = 0;
        while (item_cnt < RAND_ITEMS)
        begin
            if ($urandom_range(0, 5) == 0)
                write_mask(1'($urandom_range(0, 1)));
            if ($urandom_range(0, 9) == 0)
                drain_all();
            no_idle = (item_cnt >= 90 && item_cnt < 160);
            if ($urandom_range(0, 9) == 0)
            begin
                // noise
                repeat ($urandom_range(1, 8))
                    send_frame($urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom()),
                               1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
                continue;
            end
            nseg = $urandom_range(1, 6);
            for (int s = 0; s < nseg; s++)
            begin
                g = $urandom_range(0, 99);
                g = (g < 60) ? $urandom_range(0, 3) : (g < 92) ? $urandom_range(4, 10)
                    : $urandom_range(11, 20);
                for (int j = 0; j < g; j++)
                begin
                    if (mdl_use_mask && $urandom_range(0, 1))
                        send_frame(16'($urandom_range(1, 65535)), 1'b0, 1'b0);
                    else
                        send_frame(16'd0, 1'($urandom_range(0, 1)), 1'b0);
                end
                p = $urandom_range(0, 2) == 0 ? 16'($urandom_range(1, 300))
                    : 16'($urandom_range(1, 65535));
                send_frame(p, 1'b1, 1'b0);
            end
            // close the curve, sometimes on a trailing gap
            if ($urandom_range(0, 1))
            begin
                repeat ($urandom_range(0, 4))
                    send_frame(16'd0, 1'b1, 1'b0);
                send_frame(16'd0, 1'($urandom_range(0, 1)), 1'b1);
            end
            else
                send_frame(16'($urandom_range(1, 65535)), 1'b1, 1'b1);
        end
        write_mask(1'b1);
        send_frame(16'd0, 1'b0, 1'b1);

        drain_all();
        if (fail_cnt == 0)
            $display("tb_pitch_gap_log_interpolator_unit OK");
        else
            $display("tb_pitch_gap_log_interpolator_unit NOT OK");
        $finish;
    end
endmodule
